// ----- design/utf8sd_pkg.sv -----
package utf8sd_pkg;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 21;
   localparam int EXP_W  = 2;

   localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

   // default depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // one queue entry: the results caused by one byte.
   // two = 1: a U+FFFD goes out first, then cp.
   typedef struct packed {
      logic            two;
      logic [CP_W-1:0] cp;
      logic            last;
   } utf8sd_entry_type;

endpackage

// ----- design/utf8_stream_decoder.sv -----
// UTF-8 stream decoder: bytes in, 21-bit code points out.
// Input queue port: drive req_byte_in and req_end_of_stream with req_push;
//   a beat is taken on a clock edge with req_push high and req_full low.
// Result queue port: while rsp_empty is low, rsp_char and
//   rsp_last_of_stream show the oldest result; rsp_pop takes it.
// Malformed input gives U+FFFD. An interrupted sequence gives U+FFFD and the
//   byte is decoded again as a lead byte, so one byte can give two results.
//   rsp_last_of_stream marks the final result of each stream.
// Path: a byte's result is written into the queue, then loaded into the output register.
// Throughput: one byte per cycle while req_full is low. The back end sends
//   one result per cycle while rsp_pop keeps up; if a byte gives two results,
//   the QUEUE_DEPTH entry queue between front and back end absorbs the wait.
// Stalls: when rsp_pop stays low the output register holds, the queue fills
//   and req_full rises; no beat is lost.
// Reset (synchronous, active high): decoder state, queue and output register
//   clear at once; the next byte starts a new stream.
module utf8_stream_decoder
   import utf8sd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [BYTE_W-1:0] req_byte_in,
   input  logic              req_end_of_stream,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [CP_W-1:0]   rsp_char,
   output logic              rsp_last_of_stream
);

   // front -> queue
   logic             ent_push;
   utf8sd_entry_type ent_data;
   logic             q_full;

   // queue -> back
   logic             q_valid;
   utf8sd_entry_type q_data;
   logic             q_pop;

   assign req_full = q_full;

   // front end: keeps partial code point, classifies each byte
   utf8sd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_byte_in       (req_byte_in),
      .req_end_of_stream (req_end_of_stream),
      .q_full            (q_full),
      .ent_push          (ent_push),
      .ent_data          (ent_data)
   );

   // decoupling queue, one entry per byte that causes results
   utf8sd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (ent_push),
      .wr_data  (ent_data),
      .full     (q_full),
      .rd_en    (q_pop),
      .rd_valid (q_valid),
      .rd_data  (q_data)
   );

   // back end: splits two-result entries, drives the output register
   utf8sd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_data             (q_data),
      .q_pop              (q_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_char           (rsp_char),
      .rsp_last_of_stream (rsp_last_of_stream)
   );

endmodule

// ----- design/utf8sd_front.sv -----
module utf8sd_front
   import utf8sd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic [BYTE_W-1:0]  req_byte_in,
   input  logic               req_end_of_stream,
   input  logic               q_full,
   output logic               ent_push,
   output utf8sd_entry_type   ent_data
);

   logic [CP_W-1:0]  part_ff, part_in;
   logic [EXP_W-1:0] exp_ff, exp_in;

   logic             accept;
   logic             cont_byte;
   logic [EXP_W-1:0] lead_exp;
   logic [CP_W-1:0]  lead_part;
   logic             lead_emit;
   logic [CP_W-1:0]  lead_cp;
   logic [CP_W-1:0]  cont_part;
   logic [EXP_W-1:0] cont_exp;
   logic             r_int, r_lead, r_cont, r_trunc;
   logic [EXP_W-1:0] exp_mid;
   logic [CP_W-1:0]  part_mid;

   assign accept    = req_push && !q_full;
   assign cont_byte = (req_byte_in[7:6] == 2'b10);
   assign cont_part = {part_ff[CP_W-7:0], req_byte_in[5:0]};
   assign cont_exp  = EXP_W'(exp_ff - 2'd1);

   // lead byte decode
   always_comb begin
      lead_exp  = '0;
      lead_part = '0;
      lead_emit = 1'b0;
      lead_cp   = REPLACEMENT_CP;
      if (req_byte_in[7:3] == 5'b11110) begin
         lead_exp  = 2'd3;
         lead_part = {18'd0, req_byte_in[2:0]};
      end else if (req_byte_in[7:4] == 4'b1110) begin
         lead_exp  = 2'd2;
         lead_part = {17'd0, req_byte_in[3:0]};
      end else if (req_byte_in[7:5] == 3'b110) begin
         lead_exp  = 2'd1;
         lead_part = {16'd0, req_byte_in[4:0]};
      end else if (!req_byte_in[7]) begin
         lead_emit = 1'b1;
         lead_cp   = {14'd0, req_byte_in[6:0]};
      end else begin
         lead_emit = 1'b1;  // stray continuation or 0xF8..0xFF
      end
   end

   always_comb begin
      r_int    = 1'b0;
      r_lead   = 1'b0;
      r_cont   = 1'b0;
      exp_mid  = lead_exp;
      part_mid = lead_part;
      if (exp_ff != '0 && cont_byte) begin
         exp_mid  = cont_exp;
         part_mid = cont_part;
         r_cont   = (cont_exp == '0);
      end else begin
         r_int  = (exp_ff != '0);
         r_lead = lead_emit;
      end
      r_trunc = req_end_of_stream && (exp_mid != '0);

      exp_in  = exp_mid;
      part_in = (r_cont) ? '0 : part_mid;
      if (req_end_of_stream) begin
         exp_in  = '0;
         part_in = '0;
      end

      ent_push      = accept && (r_int || r_lead || r_cont || r_trunc);
      ent_data.two  = r_int && (r_lead || r_trunc);
      ent_data.last = req_end_of_stream;
      if (r_lead)
         ent_data.cp = lead_cp;
      else if (r_cont)
         ent_data.cp = cont_part;
      else
         ent_data.cp = REPLACEMENT_CP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff  <= '0;
         part_ff <= '0;
      end else if (accept) begin
         exp_ff  <= exp_in;
         part_ff <= part_in;
      end
   end

`ifndef SYNTHESIS
   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_stream |=> exp_ff == '0 && part_ff == '0)
      else $error("state not cleared after end of stream");
   a_eos_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_stream |-> ent_push)
      else $error("end-of-stream byte produced no result");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !ent_push)
      else $error("entry pushed into a full queue");
`endif

endmodule

// ----- design/utf8sd_queue.sv -----
module utf8sd_queue
   import utf8sd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  utf8sd_entry_type  wr_data,
   output logic              full,
   input  logic              rd_en,
   output logic              rd_valid,
   output utf8sd_entry_type  rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   utf8sd_entry_type slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_wr, do_rd;

   assign full     = (count_ff == CW'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr)
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_ff + 1'b1);
      if (do_rd)
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_ff + 1'b1);
      if (do_wr && !do_rd)
         count_in = CW'(count_ff + 1'b1);
      else if (do_rd && !do_wr)
         count_in = CW'(count_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr)
         slot_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

// ----- design/utf8sd_back.sv -----
module utf8sd_back
   import utf8sd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  utf8sd_entry_type  q_data,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [CP_W-1:0]   rsp_char,
   output logic              rsp_last_of_stream
);

   logic            out_valid_ff, out_valid_in;
   logic [CP_W-1:0] out_cp_ff, out_cp_in;
   logic            out_last_ff, out_last_in;
   logic            phase_ff, phase_in;   // first half of a two-result entry sent
   logic            load;

   assign load = q_valid && (!out_valid_ff || rsp_pop);

   always_comb begin
      out_valid_in = out_valid_ff;
      out_cp_in    = out_cp_ff;
      out_last_in  = out_last_ff;
      phase_in     = phase_ff;
      q_pop        = 1'b0;
      if (load) begin
         out_valid_in = 1'b1;
         if (q_data.two && !phase_ff) begin
            out_cp_in   = REPLACEMENT_CP;
            out_last_in = 1'b0;
            phase_in    = 1'b1;
         end else begin
            out_cp_in   = q_data.cp;
            out_last_in = q_data.last;
            phase_in    = 1'b0;
            q_pop       = 1'b1;
         end
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
      out_cp_ff   <= out_cp_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_char           = out_cp_ff;
   assign rsp_last_of_stream = out_last_ff;

`ifndef SYNTHESIS
   a_phase_holds_entry: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> q_valid)
      else $error("second result pending with empty queue");
   a_phase_first_fffd: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> out_valid_ff && out_cp_ff == REPLACEMENT_CP && !out_last_ff)
      else $error("first of two results is not a plain U+FFFD");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_char)
         && $stable(rsp_last_of_stream))
      else $error("result changed while stalled");
`endif

endmodule
